### rtl/lz77_pkg.sv
package lz77_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 4096;

  localparam logic [7:0] SIGNATURE = 8'h10;
  localparam logic [4:0] MIN_MATCH = 5'd3;

  // Decoder phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEN0   = 3'd1;
  localparam logic [2:0] PH_LEN1   = 3'd2;
  localparam logic [2:0] PH_LEN2   = 3'd3;
  localparam logic [2:0] PH_FLAG   = 3'd4;
  localparam logic [2:0] PH_TOKEN  = 3'd5;
  localparam logic [2:0] PH_REF_LO = 3'd6;

  // One result word as it waits in the output queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       bad;
  } out_word_t;

endpackage

### rtl/lz77_type10_decompressor_core.sv
// LZ77 type 0x10 stream decompressor.
//
// Compressed bytes arrive as words on the s_ channel; s_tuser marks the signature
// byte that opens a new stream. Decompressed bytes leave as words on the m_ channel,
// with m_tlast on the final word caused by one input byte, m_tuser[0] on the last
// byte of the stream and m_tuser[1] on the single word that reports a bad signature.
//
// Header, flag and reference high bytes produce nothing and are taken one a cycle
// while the output queue has room. A literal byte enters the output queue in the
// cycle it is accepted. A reference of n bytes (3 to 18, fewer at the stream end) is
// copied from the history memory through its single read port, one byte per cycle
// while the queue has room. Its low byte holds the input off until the copy is over.
//
// The history memory is never cleared. Writes run sequentially from address zero
// and a wrap flag records whether every entry has been written since reset, so any
// entry beyond the write pointer before the first wrap reads as zero. Reset is thus
// immediate and the block accepts input in the first cycle after it.
//
// A two-word output queue parts the two sides: when the receiver stalls, copying
// pauses and the input is held off once the queue is full. Nothing is lost.
module lz77_type10_decompressor_core #(
  parameter int unsigned WINDOW_DEPTH = lz77_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tuser,   // frame_start
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // last_of_run
  output logic [1:0] m_tuser    // [0] stream_done, [1] bad_header
);
  import lz77_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(WINDOW_DEPTH);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  // History memory and its bookkeeping
  logic [7:0]    hist [WINDOW_DEPTH];
  logic [AW-1:0] wp;
  logic          wrapped;
  logic [7:0]    rd_data;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic          rd_blank;

  // Decoder state
  logic [2:0]  phase;
  logic [23:0] remaining;
  logic [7:0]  flag_bits;
  logic [2:0]  flag_pos;
  logic [7:0]  hi_byte;

  // Copy sequencer
  logic          copy_active;
  logic [4:0]    copy_count;
  logic [AW-1:0] copy_src;
  logic          p_valid;
  logic          p_last;
  logic          p_done;

  // Output queue
  out_word_t fifo_mem [2];
  logic      fifo_wr;
  logic      fifo_rd;
  logic [1:0] fifo_count;

  logic          in_acc;
  logic          pop;
  logic          push;
  out_word_t     push_word;
  logic          lit_write;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic [7:0]    copy_byte;
  logic          issue;
  logic [2:0]    slots;
  logic          tok_is_ref;
  logic [2:0]    pos_adv;
  logic [23:0]   rem_dec;
  logic [AW:0]   back_dist;
  logic [AW:0]   src_calc;
  logic          issue_last;

  assign pop      = m_tvalid && m_tready;
  assign s_tready = !copy_active && !p_valid && (fifo_count != 2'd2);
  assign in_acc   = s_tvalid && s_tready;

  assign slots = {1'b0, fifo_count} + {2'b00, p_valid} - {2'b00, pop};
  assign issue = copy_active && (slots < 3'd2);

  assign tok_is_ref = flag_bits[3'd7 - flag_pos];
  assign pos_adv    = flag_pos + 3'd1;
  assign rem_dec    = remaining - 24'd1;
  assign issue_last = (copy_count == 5'd1) || (remaining == 24'd1);

  assign back_dist = (AW + 1)'({hi_byte[3:0], s_tdata}) + 1'b1;
  assign src_calc = ({1'b0, wp} >= back_dist) ? ({1'b0, wp} - back_dist)
                                              : ({1'b0, wp} + DEPTH_W - back_dist);

  assign lit_write = in_acc && !s_tuser && (phase == PH_TOKEN) && !tok_is_ref;

  assign copy_byte = fwd_hit ? fwd_data : (rd_blank ? 8'h00 : rd_data);
  assign wr_en     = lit_write || p_valid;
  assign wr_data   = p_valid ? copy_byte : s_tdata;

  always_comb begin
    push      = 1'b0;
    push_word = '{data: wr_data, last: 1'b1, done: (remaining == 24'd1), bad: 1'b0};
    if (p_valid) begin
      push      = 1'b1;
      push_word = '{data: copy_byte, last: p_last, done: p_done, bad: 1'b0};
    end else if (in_acc && s_tuser && (s_tdata != SIGNATURE)) begin
      push      = 1'b1;
      push_word = '{data: 8'h00, last: 1'b1, done: 1'b0, bad: 1'b1};
    end else if (lit_write) begin
      push = 1'b1;
    end
  end

  // History memory: one write port, one registered read port at the copy source.
  // A read of the entry written in the same cycle takes the new byte instead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wp] <= wr_data;
    end
    rd_data  <= hist[copy_src];
    fwd_hit  <= wr_en && (copy_src == wp);
    fwd_data <= wr_data;
    rd_blank <= !(wrapped || (copy_src < wp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      wrapped     <= 1'b0;
      phase       <= PH_IDLE;
      remaining   <= '0;
      flag_bits   <= '0;
      flag_pos    <= '0;
      hi_byte     <= '0;
      copy_active <= 1'b0;
      copy_count  <= '0;
      copy_src    <= '0;
      p_valid     <= 1'b0;
      p_last      <= 1'b0;
      p_done      <= 1'b0;
    end else begin
      if (wr_en) begin
        wp <= wrap_inc(wp);
        if (wp == LAST_ADDR) begin
          wrapped <= 1'b1;
        end
      end

      p_valid <= issue;
      if (issue) begin
        p_last     <= issue_last;
        p_done     <= (remaining == 24'd1);
        remaining  <= rem_dec;
        copy_count <= copy_count - 5'd1;
        copy_src   <= wrap_inc(copy_src);
        if (issue_last) begin
          copy_active <= 1'b0;
          flag_pos    <= pos_adv;
          if (rem_dec == 24'd0) begin
            phase <= PH_IDLE;
          end else if (pos_adv == 3'd0) begin
            phase <= PH_FLAG;
          end else begin
            phase <= PH_TOKEN;
          end
        end
      end

      if (in_acc) begin
        if (s_tuser) begin
          flag_bits <= '0;
          flag_pos  <= '0;
          remaining <= '0;
          phase     <= (s_tdata == SIGNATURE) ? PH_LEN0 : PH_IDLE;
        end else begin
          unique case (phase)
            PH_LEN0: begin
              remaining <= {16'h0000, s_tdata};
              phase     <= PH_LEN1;
            end
            PH_LEN1: begin
              remaining[15:8] <= s_tdata;
              phase           <= PH_LEN2;
            end
            PH_LEN2: begin
              remaining[23:16] <= s_tdata;
              flag_pos         <= '0;
              phase <= ({s_tdata, remaining[15:0]} == 24'd0) ? PH_IDLE : PH_FLAG;
            end
            PH_FLAG: begin
              flag_bits <= s_tdata;
              flag_pos  <= '0;
              phase     <= PH_TOKEN;
            end
            PH_TOKEN: begin
              if (tok_is_ref) begin
                hi_byte <= s_tdata;
                phase   <= PH_REF_LO;
              end else begin
                remaining <= rem_dec;
                flag_pos  <= pos_adv;
                if (rem_dec == 24'd0) begin
                  phase <= PH_IDLE;
                end else if (pos_adv == 3'd0) begin
                  phase <= PH_FLAG;
                end else begin
                  phase <= PH_TOKEN;
                end
              end
            end
            PH_REF_LO: begin
              // The copy runs from here; the phase moves on when it ends.
              copy_active <= 1'b1;
              copy_count  <= {1'b0, hi_byte[7:4]} + MIN_MATCH;
              copy_src    <= src_calc[AW-1:0];
            end
            default: begin
              phase <= PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  // Two-word output queue
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[fifo_wr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr    <= 1'b0;
      fifo_rd    <= 1'b0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        fifo_wr <= !fifo_wr;
      end
      if (pop) begin
        fifo_rd <= !fifo_rd;
      end
      fifo_count <= fifo_count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_tvalid = (fifo_count != 2'd0);
  assign m_tdata  = fifo_mem[fifo_rd].data;
  assign m_tlast  = fifo_mem[fifo_rd].last;
  assign m_tuser  = {fifo_mem[fifo_rd].bad, fifo_mem[fifo_rd].done};

  // The queue never takes a word it has no room for.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && (fifo_count == 2'd2) && !pop))
    else $error("output queue overflow");

  // The final copied byte of a token leaves the sequencer only once it has stopped.
  a_copy_end: assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_last) |-> !copy_active)
    else $error("copy still running after its last byte");

  // A byte flagged as the end of the stream leaves no count behind.
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (push && push_word.done) |=> (remaining == 24'd0))
    else $error("stream end flagged with bytes remaining");

  // A bad signature report carries a zero byte and closes its run.
  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    (push && push_word.bad) |-> (push_word.data == 8'h00) && push_word.last)
    else $error("malformed error word");

endmodule

### sim/lz77_type10_decompressor_core_test.sv
`timescale 1ns / 1ps

module lz77_type10_decompressor_core_test;
  import lz77_pkg::*;

  // Mirrors the decompressor: it keeps its own history window and stream state.
  // It turns every accepted input word into the output words it should cause,
  // and it compares the words that leave the block against them in order.
  class lz77_unpacker_model;
    logic [7:0]  window [WINDOW_DEPTH_DEF];
    logic [11:0] wr_ptr;
    logic [23:0] remaining;
    logic [7:0]  flags;
    logic [2:0]  flag_pos;
    logic [2:0]  phase;
    logic [7:0]  ref_high;
    out_word_t   expected_bytes[$];
    int          mismatches;

    function new();
      foreach (window[i]) window[i] = 8'h00;
      wr_ptr     = '0;
      remaining  = '0;
      flags      = '0;
      flag_pos   = '0;
      phase      = PH_IDLE;
      ref_high   = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    // Every produced byte also goes into the history, so later copies can see it.
    function void emit_byte(logic [7:0] b);
      out_word_t w;
      window[wr_ptr] = b;
      wr_ptr    = wr_ptr + 12'd1;
      remaining = remaining - 24'd1;
      w.data = b;
      w.last = 1'b0;
      w.done = (remaining == 24'd0);
      w.bad  = 1'b0;
      expected_bytes.push_back(w);
    endfunction

    function void next_token();
      flag_pos = flag_pos + 3'd1;
      if (remaining == 24'd0) phase = PH_IDLE;
      else if (flag_pos == 3'd0) phase = PH_FLAG;
      else phase = PH_TOKEN;
    endfunction

    function void take_input(logic [7:0] b, logic start);
      int          n_before;
      logic [4:0]  count;
      logic [12:0] back_dist;
      logic [11:0] src;
      out_word_t   w;
      n_before = expected_bytes.size();
      if (start) begin
        flags     = '0;
        flag_pos  = '0;
        remaining = '0;
        if (b != SIGNATURE) begin
          // A wrong signature gives a single error word and drops the stream.
          phase  = PH_IDLE;
          w.data = 8'h00;
          w.last = 1'b1;
          w.done = 1'b0;
          w.bad  = 1'b1;
          expected_bytes.push_back(w);
        end else begin
          phase = PH_LEN0;
        end
        return;
      end
      case (phase)
        PH_LEN0: begin
          remaining = {16'h0000, b};
          phase     = PH_LEN1;
        end
        PH_LEN1: begin
          remaining[15:8] = b;
          phase           = PH_LEN2;
        end
        PH_LEN2: begin
          remaining[23:16] = b;
          flag_pos         = '0;
          phase            = (remaining == 24'd0) ? PH_IDLE : PH_FLAG;
        end
        PH_FLAG: begin
          flags    = b;
          flag_pos = '0;
          phase    = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flags[3'd7 - flag_pos]) begin
            ref_high = b;
            phase    = PH_REF_LO;
          end else begin
            emit_byte(b);
            next_token();
          end
        end
        PH_REF_LO: begin
          // Byte-by-byte copy so that a short distance repeats recent output;
          // the copy is cut short when the stream length runs out.
          count     = {1'b0, ref_high[7:4]} + MIN_MATCH;
          back_dist = {1'b0, ref_high[3:0], b} + 13'd1;
          while (count != 5'd0 && remaining != 24'd0) begin
            src = wr_ptr - back_dist[11:0];
            emit_byte(window[src]);
            count = count - 5'd1;
          end
          next_token();
        end
        default: phase = PH_IDLE;
      endcase
      if (expected_bytes.size() > n_before) begin
        w = expected_bytes.pop_back();
        w.last = 1'b1;
        expected_bytes.push_back(w);
      end
    endfunction

    function void match_output(logic [7:0] data, logic last, logic done, logic bad);
      out_word_t w;
      if (expected_bytes.size() == 0) begin
        $error("output word with nothing expected: out_byte %02h", data);
        mismatches++;
        return;
      end
      w = expected_bytes.pop_front();
      if (data !== w.data) begin
        $error("out_byte: expected %02h, actual %02h", w.data, data);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("last_of_run: expected %0b, actual %0b", w.last, last);
        mismatches++;
      end
      if (done !== w.done) begin
        $error("stream_done: expected %0b, actual %0b", w.done, done);
        mismatches++;
      end
      if (bad !== w.bad) begin
        $error("bad_header: expected %0b, actual %0b", w.bad, bad);
        mismatches++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  lz77_unpacker_model unpacker;

  bit sender_gaps   = 1'b1;
  bit reader_stalls = 1'b1;
  int stall_left    = 0;
  int cycle_count   = 0;
  int words_sent    = 0;

  lz77_type10_decompressor_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: ready most of the time, with stalls of random length in bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (reader_stalls && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      unpacker.match_output(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid stays high
  // afterwards so that back-to-back words need no second assignment in a step.
  task automatic push_word(input logic [7:0] b, input logic start);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Words that an idle block merely drops are not counted.
    if (start || !unpacker.is_idle()) words_sent++;
    unpacker.take_input(b, start);
  endtask

  // Holds the input off until every expected output word has left the block.
  task automatic drain_output();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (unpacker.pending() != 0) @(posedge clk);
  endtask

  // A well-formed stream with random tokens. A non-negative cut_after stops it
  // after that many tokens, leaving it open for the next signature to break in.
  task automatic send_stream(input logic [23:0] len, input int cut_after);
    logic [7:0] flag_byte;
    logic [7:0] hi;
    logic [7:0] lo;
    int         produced;
    int         tokens;
    int         left;
    int         copy_len;
    push_word(SIGNATURE, 1'b1);
    push_word(len[7:0], 1'b0);
    push_word(len[15:8], 1'b0);
    push_word(len[23:16], 1'b0);
    produced = 0;
    tokens   = 0;
    while (produced < len && tokens != cut_after) begin
      flag_byte = 8'($urandom);
      push_word(flag_byte, 1'b0);
      for (int i = 0; i < 8 && produced < len && tokens != cut_after; i++) begin
        if (flag_byte[7 - i]) begin
          hi = 8'($urandom);
          // Mostly short distances, which overlap recent output; some reach
          // anywhere in the window, into older streams or untouched entries.
          if ($urandom_range(0, 3) == 0) {hi[3:0], lo} = 12'($urandom);
          else {hi[3:0], lo} = 12'($urandom_range(0, 7));
          push_word(hi, 1'b0);
          push_word(lo, 1'b0);
          copy_len = hi[7:4] + 3;
          left     = len - produced;
          produced += (copy_len < left) ? copy_len : left;
        end else begin
          push_word(8'($urandom), 1'b0);
          produced++;
        end
        tokens++;
      end
    end
  endtask

  initial begin
    bit pause_done;
    unpacker   = new();
    pause_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wrong signature at the top of the byte range, then a word while idle.
    push_word(8'hFF, 1'b1);
    push_word(SIGNATURE, 1'b0);
    // Zero-length stream: no output at all.
    push_word(SIGNATURE, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    // Largest length, one literal zero, then a restart in the middle.
    push_word(SIGNATURE, 1'b1);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    // Twenty bytes: literal FF, an 18-byte copy at distance one, then a copy
    // from the far end of the window that the length cuts to one byte, then a
    // trailing word after the stream has ended.
    push_word(SIGNATURE, 1'b1);
    push_word(8'h14, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h60, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hF0, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h0F, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h55, 1'b0);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      // The closing stretch runs without idling on either side.
      if (words_sent > RANDOM_WORDS - 40) begin
        sender_gaps   = 1'b0;
        reader_stalls = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: push_word(8'($urandom), 1'($urandom_range(0, 1)));
        1: send_stream(24'($urandom_range(1, 60)), $urandom_range(0, 6));
        2: send_stream({8'($urandom), 16'($urandom)}, $urandom_range(1, 4));
        default: send_stream(24'($urandom_range(1, 40)), -1);
      endcase
      if (!pause_done && words_sent > 60) begin
        drain_output();
        pause_done = 1'b1;
      end
    end

    drain_output();
    repeat (40) @(posedge clk);
    if (unpacker.mismatches == 0 && unpacker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
